// ===== design/transparent_glyph_blitter_defines.svh =====
// Assertion helpers shared by the glyph blitter RTL.
`ifndef TRANSPARENT_GLYPH_BLITTER_DEFINES_SVH
`define TRANSPARENT_GLYPH_BLITTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TGB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TGB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tgb_pkg.sv =====
package tgb_pkg;

    // Input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    // Bus operation kinds
    typedef enum logic [1:0] {
        OP_REG_WRITE   = 2'd0,
        OP_INDEX_WRITE = 2'd1,
        OP_DATA_WRITE  = 2'd2,
        OP_COPY_BG     = 2'd3
    } t_op_kind;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ORIGIN_X     = 3'd0,
        CFG_ORIGIN_Y     = 3'd1,
        CFG_GLYPH_WIDTH  = 3'd2,
        CFG_GLYPH_HEIGHT = 3'd3,
        CFG_INK_COLOR    = 3'd4,
        CFG_ROTATED      = 3'd5
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Controller registers and values
    localparam logic [15:0] REG_ENTRY_MODE = 16'h0003;
    localparam logic [15:0] ENTRY_NORMAL   = 16'h1030;
    localparam logic [15:0] ENTRY_ROTATED  = 16'h1018;
    localparam logic [15:0] REG_H_START    = 16'h0210;
    localparam logic [15:0] REG_H_END      = 16'h0211;
    localparam logic [15:0] REG_V_START    = 16'h0212;
    localparam logic [15:0] REG_V_END      = 16'h0213;
    localparam logic [15:0] REG_GRAM_H     = 16'h0200;
    localparam logic [15:0] REG_GRAM_V     = 16'h0201;
    localparam logic [15:0] REG_GRAM_DATA  = 16'h0202;

    // Eight operations per request, step counter ends here
    localparam logic [2:0] SEQ_LAST = 3'd7;

    localparam int CMD_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [8:0]  origin_x;
        logic [8:0]  origin_y;
        logic [8:0]  glyph_width;
        logic [8:0]  glyph_height;
        logic [15:0] ink_color;
        logic        rotated;
    } t_cfg;

    typedef struct packed {
        logic       is_start;
        logic [7:0] bits;
    } t_cmd;

    typedef struct packed {
        t_op_kind    kind;
        logic [15:0] reg_index;
        logic [15:0] data_value;
        logic [15:0] horiz_addr;
        logic [15:0] vert_addr;
        logic        last_op;
    } t_op;

endpackage

// ===== design/tgb_front.sv =====
module tgb_front import tgb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_action,
    input  logic [7:0] i_glyph_byte,
    input  t_cfg       i_cfg,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd
);

    logic        r_drawing;
    logic [17:0] r_pixels;
    logic [17:0] w_size;
    logic [17:0] n_pixels;
    logic        w_is_start;
    logic        w_remaining;

    assign w_size      = {9'd0, i_cfg.glyph_width} * {9'd0, i_cfg.glyph_height};
    assign n_pixels    = r_pixels + 18'd8;
    assign w_is_start  = (i_action == ACT_START);
    assign w_remaining = r_drawing && (r_pixels < w_size);

    // Forward starts and bytes that still have pixels; drop the rest here
    assign o_cmd_valid   = i_accept && (w_is_start || w_remaining);
    assign o_cmd.is_start = w_is_start;
    assign o_cmd.bits     = i_glyph_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drawing <= 1'b0;
            r_pixels  <= '0;
        end else if (i_accept) begin
            if (w_is_start) begin
                r_drawing <= 1'b1;
                r_pixels  <= '0;
            end else if (r_drawing) begin
                if (!w_remaining) begin
                    r_drawing <= 1'b0;
                end else begin
                    r_pixels <= n_pixels;
                    if (n_pixels >= w_size) begin
                        r_drawing <= 1'b0;
                    end
                end
            end
        end
    end

endmodule

// ===== design/tgb_cmd_queue.sv =====
`include "transparent_glyph_blitter_defines.svh"

module tgb_cmd_queue import tgb_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wr_cmd,
    input  logic i_rd,
    output logic o_full,
    output logic o_nonempty,
    output t_cmd o_rd_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_rd_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_wr, i_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `TGB_ASSERT_NOW(a_q_no_overflow, i_clk, i_rst_n, i_wr, !o_full || i_rd, "queue write while full")
    `TGB_ASSERT_NOW(a_q_no_underflow, i_clk, i_rst_n, i_rd, o_nonempty, "queue read while empty")
    `TGB_ASSERT_NEXT(a_q_count_up, i_clk, i_rst_n, i_wr && !i_rd, r_count == $past(r_count) + 1'b1, "queue count did not advance")

endmodule

// ===== design/tgb_back.sv =====
`include "transparent_glyph_blitter_defines.svh"

module tgb_back import tgb_pkg::*; #(
    parameter int unsigned PANEL_LAST_LINE = 399
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_q_nonempty,
    input  t_cmd i_q_cmd,
    output logic o_q_rd,
    input  logic i_pop,
    output logic o_op_valid,
    output t_op  o_op
);

    localparam logic [15:0] LAST_LINE = 16'(PANEL_LAST_LINE);

    logic       r_busy;
    logic [2:0] r_step;
    logic       r_is_start;
    logic [7:0] r_bits;
    logic [8:0] r_col;
    logic [8:0] r_row;
    logic       r_out_valid;
    t_op        r_out;

    logic        w_out_ready;
    logic        w_issue;
    logic        w_seq_end;
    logic        w_take;
    logic [8:0]  n_col;
    logic [15:0] w_x0;
    logic [15:0] w_y0;
    logic [15:0] w_xe;
    logic [15:0] w_ye;
    logic [15:0] w_px;
    logic [15:0] w_py;
    t_op         w_op;

    assign w_out_ready = !r_out_valid || i_pop;
    assign w_issue     = r_busy && w_out_ready;
    assign w_seq_end   = w_issue && (r_step == SEQ_LAST);
    assign w_take      = i_q_nonempty && (!r_busy || w_seq_end);
    assign o_q_rd      = w_take;

    assign w_x0 = {7'd0, i_cfg.origin_x};
    assign w_y0 = {7'd0, i_cfg.origin_y};
    assign w_xe = w_x0 + {7'd0, i_cfg.glyph_width} - 16'd1;
    assign w_ye = w_y0 + {7'd0, i_cfg.glyph_height} - 16'd1;
    assign w_px = w_x0 + {7'd0, r_col};
    assign w_py = w_y0 + {7'd0, r_row};
    assign n_col = r_col + 9'd1;

    always_comb begin
        w_op         = '0;
        w_op.last_op = (r_step == SEQ_LAST);
        if (r_is_start) begin
            w_op.kind = OP_REG_WRITE;
            unique case (r_step)
                3'd0: begin
                    w_op.reg_index  = REG_ENTRY_MODE;
                    w_op.data_value = i_cfg.rotated ? ENTRY_ROTATED : ENTRY_NORMAL;
                end
                3'd1: begin
                    w_op.reg_index  = REG_H_START;
                    w_op.data_value = i_cfg.rotated ? w_y0 : w_x0;
                end
                3'd2: begin
                    w_op.reg_index  = REG_H_END;
                    w_op.data_value = i_cfg.rotated ? w_ye : w_xe;
                end
                3'd3: begin
                    w_op.reg_index  = REG_V_START;
                    w_op.data_value = i_cfg.rotated ? LAST_LINE - w_xe : w_y0;
                end
                3'd4: begin
                    w_op.reg_index  = REG_V_END;
                    w_op.data_value = i_cfg.rotated ? LAST_LINE - w_x0 : w_ye;
                end
                3'd5: begin
                    w_op.reg_index  = REG_GRAM_H;
                    w_op.data_value = i_cfg.rotated ? w_y0 : w_x0;
                end
                3'd6: begin
                    w_op.reg_index  = REG_GRAM_V;
                    w_op.data_value = i_cfg.rotated ? LAST_LINE - w_x0 : w_y0;
                end
                3'd7: begin
                    w_op.kind      = OP_INDEX_WRITE;
                    w_op.reg_index = REG_GRAM_DATA;
                end
                default: begin
                    w_op.kind = OP_REG_WRITE;
                end
            endcase
        end else if (r_bits[7]) begin
            w_op.kind       = OP_DATA_WRITE;
            w_op.data_value = i_cfg.ink_color;
        end else begin
            w_op.kind       = OP_COPY_BG;
            w_op.horiz_addr = i_cfg.rotated ? w_py : w_px;
            w_op.vert_addr  = i_cfg.rotated ? LAST_LINE - w_px : w_py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_is_start <= i_q_cmd.is_start;
            r_bits     <= i_q_cmd.bits;
        end else if (w_issue) begin
            r_bits <= {r_bits[6:0], 1'b0};
        end
        if (w_issue) begin
            r_out <= w_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (w_issue) begin
                r_step <= r_step + 3'd1;
                if (w_seq_end) begin
                    r_busy <= 1'b0;
                end
            end
            // Advance the pixel position; a new start clears it
            if (w_issue && !r_is_start) begin
                if (n_col >= i_cfg.glyph_width) begin
                    r_col <= '0;
                    r_row <= r_row + 9'd1;
                end else begin
                    r_col <= n_col;
                end
            end
            if (w_take && i_q_cmd.is_start) begin
                r_col <= '0;
                r_row <= '0;
            end
            if (w_issue) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_op_valid = r_out_valid;
    assign o_op       = r_out;

    `TGB_ASSERT_NEXT(a_seq_end_marks_last, i_clk, i_rst_n, w_seq_end, r_out_valid && r_out.last_op, "final operation not marked last")
    `TGB_ASSERT_NEXT(a_busy_holds, i_clk, i_rst_n, r_busy && !w_seq_end, r_busy, "sequencer dropped a request early")
    `TGB_ASSERT_NOW(a_take_only_when_free, i_clk, i_rst_n, w_take && r_busy, w_seq_end, "new request taken mid sequence")

endmodule

// ===== design/transparent_glyph_blitter.sv =====
// Transparent glyph blitter: turns 1-bit-per-pixel glyph data (MSB first, row-major) into
// LCD controller bus operations. A start request (action 0) yields eight operations: the
// entry-mode write, four window writes, two GRAM address writes and the GRAM data index
// write. Each glyph byte request (action 1) yields eight pixel operations: a data write of
// ink_color for a set bit, or a copy-background operation with GRAM addresses for a clear
// bit. Bytes before a start, or past width times height, are accepted and give nothing.
// Each request that produces output occupies the output sequencer for its eight operations,
// one operation per cycle when pop keeps up; a request that produces nothing is dropped at the
// input. The first operation of a request passes through the command queue, the sequencer
// registers and the output register. A four-entry command queue sits between the input
// classifier and the sequencer, so push keeps being taken while results wait, until it is full.
// Write configuration only while no request is in flight; ready on the configuration port
// is always high. last_op marks the final operation of each request.
module transparent_glyph_blitter import tgb_pkg::*; #(
    parameter int unsigned PANEL_LAST_LINE = 399
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request side
    input  logic                  push,
    output logic                  full,
    input  logic                  i_action,
    input  logic [7:0]            i_glyph_byte,
    // result side
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            o_op_kind,
    output logic [15:0]           o_reg_index,
    output logic [15:0]           o_data_value,
    output logic [15:0]           o_horiz_addr,
    output logic [15:0]           o_vert_addr,
    output logic                  o_last_op,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic w_accept;
    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_q_full;
    logic w_q_nonempty;
    t_cmd w_q_cmd;
    logic w_q_rd;
    logic w_op_valid;
    t_op  w_op;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; writes outside the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x     <= 9'd0;
            r_cfg.origin_y     <= 9'd0;
            r_cfg.glyph_width  <= 9'd8;
            r_cfg.glyph_height <= 9'd1;
            r_cfg.ink_color    <= 16'd0;
            r_cfg.rotated      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X:     r_cfg.origin_x     <= i_cfg_data[8:0];
                CFG_ORIGIN_Y:     r_cfg.origin_y     <= i_cfg_data[8:0];
                CFG_GLYPH_WIDTH:  r_cfg.glyph_width  <= i_cfg_data[8:0];
                CFG_GLYPH_HEIGHT: r_cfg.glyph_height <= i_cfg_data[8:0];
                CFG_INK_COLOR:    r_cfg.ink_color    <= i_cfg_data;
                CFG_ROTATED:      r_cfg.rotated      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Hold requests off while the command queue is full
    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    tgb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_action     (i_action),
        .i_glyph_byte (i_glyph_byte),
        .i_cfg        (r_cfg),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd)
    );

    tgb_cmd_queue #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_cmd_valid),
        .i_wr_cmd   (w_cmd),
        .i_rd       (w_q_rd),
        .o_full     (w_q_full),
        .o_nonempty (w_q_nonempty),
        .o_rd_cmd   (w_q_cmd)
    );

    tgb_back #(
        .PANEL_LAST_LINE (PANEL_LAST_LINE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_nonempty (w_q_nonempty),
        .i_q_cmd      (w_q_cmd),
        .o_q_rd       (w_q_rd),
        .i_pop        (pop),
        .o_op_valid   (w_op_valid),
        .o_op         (w_op)
    );

    // Drive the result ports from the output register
    assign empty        = !w_op_valid;
    assign o_op_kind    = w_op.kind;
    assign o_reg_index  = w_op.reg_index;
    assign o_data_value = w_op.data_value;
    assign o_horiz_addr = w_op.horiz_addr;
    assign o_vert_addr  = w_op.vert_addr;
    assign o_last_op    = w_op.last_op;

endmodule

// ===== tb/sv/transparent_glyph_blitter_tb.sv =====
module transparent_glyph_blitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tgb_pkg::*;

    localparam int unsigned PANEL_LAST_LINE = 399;
    localparam int HALF_PERIOD    = 6;
    localparam int DRAIN_PAUSE    = 24;    // covers the command queue plus pipeline
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int ITEMS_PER_PHASE = 48;
    localparam int RANDOM_PHASES   = 8;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // Track the blitter state and queue the bus operations that each accepted request
    // must produce, then match them in order against what leaves the block.
    class glyph_op_scoreboard;
        logic [15:0] last_line;
        logic [8:0]  org_x, org_y, glyph_w, glyph_h;
        logic [15:0] ink;
        logic        rotated;
        logic [8:0]  col_cnt, row_cnt;
        logic [17:0] pix_done;
        logic        drawing;
        t_op         pending_ops[$];
        int          errors;

        function new(int unsigned panel_last_line);
            last_line = 16'(panel_last_line);
            org_x     = '0;
            org_y     = '0;
            glyph_w   = 9'd8;
            glyph_h   = 9'd1;
            ink       = '0;
            rotated   = 1'b0;
            col_cnt   = '0;
            row_cnt   = '0;
            pix_done  = '0;
            drawing   = 1'b0;
            errors    = 0;
        endfunction

        function void apply_reg_write(t_cfg_idx idx, logic [15:0] data);
            case (idx)
                CFG_ORIGIN_X:     org_x   = data[8:0];
                CFG_ORIGIN_Y:     org_y   = data[8:0];
                CFG_GLYPH_WIDTH:  glyph_w = data[8:0];
                CFG_GLYPH_HEIGHT: glyph_h = data[8:0];
                CFG_INK_COLOR:    ink     = data;
                CFG_ROTATED:      rotated = data[0];
                default: ;
            endcase
        endfunction

        function void add_op(t_op_kind kind, logic [15:0] idx, logic [15:0] val,
                             logic [15:0] h, logic [15:0] v, logic is_last);
            t_op op;
            op.kind       = kind;
            op.reg_index  = idx;
            op.data_value = val;
            op.horiz_addr = h;
            op.vert_addr  = v;
            op.last_op    = is_last;
            pending_ops.push_back(op);
        endfunction

        // Expand one accepted request; return how many operations it causes.
        function int note_request(logic action, logic [7:0] pixels);
            logic [15:0] x0, y0, xe, ye, col_x, row_y;
            logic [17:0] area;
            x0   = 16'(org_x);
            y0   = 16'(org_y);
            xe   = x0 + 16'(glyph_w) - 16'd1;
            ye   = y0 + 16'(glyph_h) - 16'd1;
            area = 18'(glyph_w) * 18'(glyph_h);

            if (action == ACT_START) begin
                if (!rotated) begin
                    add_op(OP_REG_WRITE, REG_ENTRY_MODE, ENTRY_NORMAL, '0, '0, 1'b0);
                    add_op(OP_REG_WRITE, REG_H_START, x0, '0, '0, 1'b0);
                    add_op(OP_REG_WRITE, REG_H_END, xe, '0, '0, 1'b0);
                    add_op(OP_REG_WRITE, REG_V_START, y0, '0, '0, 1'b0);
                    add_op(OP_REG_WRITE, REG_V_END, ye, '0, '0, 1'b0);
                    add_op(OP_REG_WRITE, REG_GRAM_H, x0, '0, '0, 1'b0);
                    add_op(OP_REG_WRITE, REG_GRAM_V, y0, '0, '0, 1'b0);
                end else begin
                    add_op(OP_REG_WRITE, REG_ENTRY_MODE, ENTRY_ROTATED, '0, '0, 1'b0);
                    add_op(OP_REG_WRITE, REG_H_START, y0, '0, '0, 1'b0);
                    add_op(OP_REG_WRITE, REG_H_END, ye, '0, '0, 1'b0);
                    add_op(OP_REG_WRITE, REG_V_START, last_line - xe, '0, '0, 1'b0);
                    add_op(OP_REG_WRITE, REG_V_END, last_line - x0, '0, '0, 1'b0);
                    add_op(OP_REG_WRITE, REG_GRAM_H, y0, '0, '0, 1'b0);
                    add_op(OP_REG_WRITE, REG_GRAM_V, last_line - x0, '0, '0, 1'b0);
                end
                add_op(OP_INDEX_WRITE, REG_GRAM_DATA, '0, '0, '0, 1'b1);
                col_cnt  = '0;
                row_cnt  = '0;
                pix_done = '0;
                drawing  = 1'b1;
                return 8;
            end

            if (!drawing)
                return 0;
            if (pix_done >= area) begin
                drawing = 1'b0;
                return 0;
            end

            // A byte always gives eight pixels, even past a row end.
            for (int n = 0; n < 8; n++) begin
                col_x = x0 + 16'(col_cnt);
                row_y = y0 + 16'(row_cnt);
                if (pixels[7])
                    add_op(OP_DATA_WRITE, '0, ink, '0, '0, n == 7);
                else if (!rotated)
                    add_op(OP_COPY_BG, '0, '0, col_x, row_y, n == 7);
                else
                    add_op(OP_COPY_BG, '0, '0, row_y, last_line - col_x, n == 7);
                pixels  = pixels << 1;
                col_cnt = col_cnt + 9'd1;
                if (col_cnt >= glyph_w) begin
                    col_cnt = '0;
                    row_cnt = row_cnt + 9'd1;
                end
                pix_done = pix_done + 18'd1;
            end
            if (pix_done >= area)
                drawing = 1'b0;
            return 8;
        endfunction

        function int outstanding();
            return pending_ops.size();
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%h, got 0x%h", name, want, got);
                errors++;
            end
        endfunction

        function void check_op(logic [1:0] kind, logic [15:0] idx, logic [15:0] val,
                               logic [15:0] h, logic [15:0] v, logic is_last);
            t_op want;
            if (pending_ops.size() == 0) begin
                $error("op_kind %0d popped with no request outstanding", kind);
                errors++;
                return;
            end
            want = pending_ops.pop_front();
            compare_field("op_kind", {14'd0, want.kind}, {14'd0, kind});
            compare_field("reg_index", want.reg_index, idx);
            compare_field("data_value", want.data_value, val);
            compare_field("horiz_addr", want.horiz_addr, h);
            compare_field("vert_addr", want.vert_addr, v);
            compare_field("last_op", {15'd0, want.last_op}, {15'd0, is_last});
        endfunction
    endclass

    // Drive every input to a known value from time zero.
    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  push         = 1'b0;
    logic                  i_action     = 1'b0;
    logic [7:0]            i_glyph_byte = '0;
    logic                  pop          = 1'b0;
    logic                  i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;

    logic        full;
    logic        empty;
    logic [1:0]  o_op_kind;
    logic [15:0] o_reg_index;
    logic [15:0] o_data_value;
    logic [15:0] o_horiz_addr;
    logic [15:0] o_vert_addr;
    logic        o_last_op;
    logic        o_cfg_ready;

    glyph_op_scoreboard sb;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int productive_reqs = 0;   // requests that caused operations
    int quiet_cycles    = 0;
    bit progress;

    transparent_glyph_blitter #(
        .PANEL_LAST_LINE(PANEL_LAST_LINE)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_action     (i_action),
        .i_glyph_byte (i_glyph_byte),
        .empty        (empty),
        .pop          (pop),
        .o_op_kind    (o_op_kind),
        .o_reg_index  (o_reg_index),
        .o_data_value (o_data_value),
        .o_horiz_addr (o_horiz_addr),
        .o_vert_addr  (o_vert_addr),
        .o_last_op    (o_last_op),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Stall the result side at random; hold pop low through reset.
    always @(posedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Observe all three handshakes at the clock edge, in acceptance order, so that a
    // register write lands in the predictor before any later request is expanded.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            progress = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                sb.apply_reg_write(t_cfg_idx'(i_cfg_index), i_cfg_data);
                progress = 1'b1;
            end
            if (push && !full) begin
                if (sb.note_request(i_action, i_glyph_byte) > 0)
                    productive_reqs <= productive_reqs + 1;
                progress = 1'b1;
            end
            if (pop && !empty) begin
                sb.check_op(o_op_kind, o_reg_index, o_data_value, o_horiz_addr,
                            o_vert_addr, o_last_op);
                progress = 1'b1;
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Present one request, optionally after a random idle gap; return at the edge
    // where it is taken, leaving push high so the next request can follow directly.
    task automatic send_request(input logic action, input logic [7:0] pixels);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        push         <= 1'b1;
        i_action     <= action;
        i_glyph_byte <= pixels;
        do @(posedge i_clk); while (full);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [15:0] x0, input logic [15:0] y0,
                             input logic [15:0] w, input logic [15:0] h,
                             input logic [15:0] ink, input logic [15:0] rot);
        write_reg(CFG_ORIGIN_X, x0);
        write_reg(CFG_ORIGIN_Y, y0);
        write_reg(CFG_GLYPH_WIDTH, w);
        write_reg(CFG_GLYPH_HEIGHT, h);
        write_reg(CFG_INK_COLOR, ink);
        write_reg(CFG_ROTATED, rot);
    endtask

    // Drop push, wait until every expected operation has been popped, then let any
    // request that gives nothing clear the pipeline before the next register write.
    // Poll on the falling edge so the count is never read mid-update.
    task automatic settle();
        push <= 1'b0;
        do @(negedge i_clk); while (sb.outstanding() != 0);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            IDLE_SENDER:   begin send_idle_pct = 76; recv_stall_pct <= 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct <= 76; end
            default:       begin send_idle_pct = 6;  recv_stall_pct <= 6;  end
        endcase
    endtask

    // Mostly 9-bit coordinates; now and then junk in the upper bits.
    function automatic logic [15:0] rand_coord();
        return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(511));
    endfunction

    // Keep glyphs small so that most of them finish and bytes run past the end.
    task automatic random_setup();
        logic [15:0] w, h;
        w = ($urandom_range(9) == 0) ? 16'($urandom_range(511))
                                     : 16'(8 * $urandom_range(4, 1));
        h = ($urandom_range(9) == 0) ? 16'($urandom_range(40)) : 16'($urandom_range(6, 1));
        write_all(rand_coord(), rand_coord(), w, h, 16'($urandom), 16'($urandom));
    endtask

    // Mostly a whole glyph with random content (sometimes cut short by a restart,
    // sometimes followed by stray bytes); otherwise a few noise requests.
    task automatic random_burst();
        int n_bytes;
        int extra;
        if ($urandom_range(99) < 85) begin
            n_bytes = (int'(sb.glyph_w) * int'(sb.glyph_h) + 7) / 8;
            if (n_bytes > 30)
                n_bytes = $urandom_range(30, 1);
            if ($urandom_range(9) == 0 && n_bytes > 1)
                n_bytes = $urandom_range(n_bytes - 1);
            extra = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
            send_request(ACT_START, 8'($urandom));
            repeat (n_bytes + extra) send_request(ACT_BYTE, 8'($urandom));
        end else begin
            repeat ($urandom_range(4, 1))
                send_request(1'($urandom_range(1)), 8'($urandom));
        end
    endtask

    initial begin
        int target;
        sb = new(PANEL_LAST_LINE);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_idling(IDLE_NONE);

        // A byte before any start must give nothing.
        send_request(ACT_BYTE, 8'hA5);
        settle();

        // Small glyph: all background, all ink, then bytes past the end, then a restart
        // in the middle of a glyph.
        write_all(16'd0, 16'd0, 16'd8, 16'd2, 16'hFFFF, 16'd0);
        send_request(ACT_START, 8'hFF);
        send_request(ACT_BYTE, 8'h00);
        send_request(ACT_BYTE, 8'hFF);
        send_request(ACT_BYTE, 8'h81);
        send_request(ACT_BYTE, 8'h3C);
        send_request(ACT_START, 8'h00);
        send_request(ACT_BYTE, 8'h5A);
        send_request(ACT_START, 8'h00);
        send_request(ACT_BYTE, 8'hC3);
        send_request(ACT_BYTE, 8'h7E);
        settle();

        // Rotated, origin at the top of the 9-bit range so the panel math wraps, width
        // not a multiple of eight, junk above the used register bits.
        write_all(16'hFFFF, 16'hFFFF, 16'hFE0C, 16'hFE02, 16'h8001, 16'hFFFF);
        send_request(ACT_START, 8'h00);
        send_request(ACT_BYTE, 8'h00);
        send_request(ACT_BYTE, 8'hFF);
        send_request(ACT_BYTE, 8'h96);
        send_request(ACT_BYTE, 8'h12);
        settle();

        // Zero width, then zero height: setup only, no pixels.
        write_all(16'd5, 16'd7, 16'd0, 16'd5, 16'h1234, 16'd0);
        send_request(ACT_START, 8'h00);
        send_request(ACT_BYTE, 8'hFF);
        settle();
        write_reg(CFG_GLYPH_WIDTH, 16'd8);
        write_reg(CFG_GLYPH_HEIGHT, 16'd0);
        send_request(ACT_START, 8'h00);
        send_request(ACT_BYTE, 8'h0F);
        settle();

        // Largest glyph the registers allow.
        write_all(16'd0, 16'd0, 16'd511, 16'd511, 16'h5555, 16'd0);
        send_request(ACT_START, 8'h00);
        send_request(ACT_BYTE, 8'h80);
        send_request(ACT_BYTE, 8'h01);
        settle();

        // Random phases, cycling through the idling patterns.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_idling(t_idle_mode'(ph % 4));
            random_setup();
            target = productive_reqs + ITEMS_PER_PHASE;
            while (productive_reqs < target)
                random_burst();
            settle();
        end

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
